// ----- rtl/olad_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// olad_pkg
// shared types and constants for the ordered list block: command and status
// codes, and the command and status bundles between controller and datapath
// ----------------------------------------------------------------------------
package olad_pkg;

    // most results a single display transaction may produce
    localparam int RESULT_LIMIT = 16;

    typedef enum logic [1:0] {
        CMD_APPEND  = 2'd0,
        CMD_DELETE  = 2'd1,
        CMD_DISPLAY = 2'd2
    } t_command;

    typedef enum logic [2:0] {
        ST_APPENDED  = 3'd0,
        ST_DELETED   = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_EMPTY     = 3'd3,
        ST_FULL      = 3'd4,
        ST_LISTED    = 3'd5
    } t_status;

    // controller to datapath
    typedef struct packed {
        logic    latch;       // capture command and value
        logic    idx_clr;     // walk index back to head
        logic    idx_inc;     // walk index one step on
        logic    mem_rd;      // registered read of storage
        logic    rd_next;     // read at index + 1 instead of index
        logic    mem_wr;      // write storage
        logic    wr_shift;    // write read data at index, else value at tail
        logic    cnt_inc;
        logic    cnt_dec;
        logic    out_load;    // load the result register
        t_status out_status;
        logic    out_rdata;   // entry value taken from read data
        logic    out_last;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic [1:0] cmd;      // latched command code
        logic       cnt_zero;
        logic       cnt_full;
        logic       match;    // read data equals latched value
        logic       at_end;   // index is the final held entry
        logic       list_last;// index is the final entry to list
        logic       out_free; // result register can take a new result
    } t_dp_sts;

endpackage
`default_nettype wire

// ----- rtl/olad_dp.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// olad_dp
// datapath: entry storage, entry count, walk index, latched command and the
// result register
// ----------------------------------------------------------------------------
module olad_dp
    import olad_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire  [1:0]        i_command,
    input  wire  [31:0]       i_value,
    input  wire               i_out_ready,
    input  wire  t_dp_cmd     i_cmd,
    output t_dp_sts           o_sts,
    output logic              o_out_valid,
    output logic [2:0]        o_status,
    output logic signed [31:0] o_entry_value,
    output logic              o_last
);

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    logic [31:0]   mem [CAPACITY];
    logic [31:0]   r_rdata;
    logic [1:0]    r_cmd;
    logic [31:0]   r_val;
    logic [CW-1:0] r_count, n_count;
    logic [IW-1:0] r_idx, n_idx;
    logic          r_out_valid, n_out_valid;
    t_status       r_status;
    logic [31:0]   r_entry;
    logic          r_last;

    logic [IW-1:0] rd_addr, wr_addr;
    logic [31:0]   wr_data;

    assign rd_addr = i_cmd.rd_next ? r_idx + 1'b1 : r_idx;
    assign wr_addr = i_cmd.wr_shift ? r_idx : r_count[IW-1:0];
    assign wr_data = i_cmd.wr_shift ? r_rdata : r_val;

    // storage
    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_wr) begin
            mem[wr_addr] <= wr_data;
        end
        if (i_cmd.mem_rd) begin
            r_rdata <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_cmd <= i_command;
            r_val <= i_value;
        end
    end

    always_comb begin
        n_count = r_count;
        if (i_cmd.cnt_inc) begin
            n_count = r_count + 1'b1;
        end else if (i_cmd.cnt_dec) begin
            n_count = r_count - 1'b1;
        end
        n_idx = r_idx;
        if (i_cmd.idx_clr) begin
            n_idx = '0;
        end else if (i_cmd.idx_inc) begin
            n_idx = r_idx + 1'b1;
        end
        n_out_valid = r_out_valid;
        if (i_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    // result register payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_status <= i_cmd.out_status;
            r_entry  <= i_cmd.out_rdata ? r_rdata : r_val;
            r_last   <= i_cmd.out_last;
        end
    end

    always_comb begin
        o_sts.cmd       = r_cmd;
        o_sts.cnt_zero  = (r_count == '0);
        o_sts.cnt_full  = (int'(r_count) >= CAPACITY);
        o_sts.match     = (r_rdata == r_val);
        o_sts.at_end    = (int'(r_idx) + 1 >= int'(r_count));
        o_sts.list_last = (int'(r_idx) + 1 == int'(r_count)) ||
                          (int'(r_idx) + 1 == RESULT_LIMIT);
        o_sts.out_free  = !r_out_valid || i_out_ready;
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_entry_value = r_entry;
    assign o_last        = r_last;

endmodule
`default_nettype wire

// ----- rtl/olad_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// olad_ctrl
// controller: one-hot sequencer for append, search, compaction and display
// ----------------------------------------------------------------------------
module olad_ctrl
    import olad_pkg::*;
(
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  wire           i_in_valid,
    output logic          o_in_ready,
    input  wire  t_dp_sts i_sts,
    output t_dp_cmd       o_cmd
);

    typedef enum logic [9:0] {
        S_IDLE     = 10'b00_0000_0001,
        S_DECODE   = 10'b00_0000_0010,
        S_SRCH_RD  = 10'b00_0000_0100,
        S_SRCH_CMP = 10'b00_0000_1000,
        S_SHF_CHK  = 10'b00_0001_0000,
        S_SHF_RD   = 10'b00_0010_0000,
        S_SHF_WR   = 10'b00_0100_0000,
        S_DSP_RD   = 10'b00_1000_0000,
        S_DSP_OUT  = 10'b01_0000_0000,
        S_EMIT     = 10'b10_0000_0000
    } t_state;

    t_state  r_state, n_state;
    t_status r_pend, n_pend;

    always_comb begin
        n_state    = r_state;
        n_pend     = r_pend;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_DECODE;
                end
            end
            S_DECODE: begin
                o_cmd.idx_clr = 1'b1;
                case (i_sts.cmd)
                    CMD_APPEND: begin
                        if (i_sts.cnt_full) begin
                            n_pend = ST_FULL;
                        end else begin
                            o_cmd.mem_wr  = 1'b1;
                            o_cmd.cnt_inc = 1'b1;
                            n_pend        = ST_APPENDED;
                        end
                        n_state = S_EMIT;
                    end
                    CMD_DELETE: begin
                        if (i_sts.cnt_zero) begin
                            n_pend  = ST_EMPTY;
                            n_state = S_EMIT;
                        end else begin
                            n_state = S_SRCH_RD;
                        end
                    end
                    CMD_DISPLAY: begin
                        if (i_sts.cnt_zero) begin
                            n_pend  = ST_EMPTY;
                            n_state = S_EMIT;
                        end else begin
                            n_state = S_DSP_RD;
                        end
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_SRCH_RD: begin
                o_cmd.mem_rd = 1'b1;
                n_state      = S_SRCH_CMP;
            end
            S_SRCH_CMP: begin
                if (i_sts.match) begin
                    n_state = S_SHF_CHK;
                end else if (i_sts.at_end) begin
                    n_pend  = ST_NOT_FOUND;
                    n_state = S_EMIT;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    n_state       = S_SRCH_RD;
                end
            end
            S_SHF_CHK: begin
                if (i_sts.at_end) begin
                    o_cmd.cnt_dec = 1'b1;
                    n_pend        = ST_DELETED;
                    n_state       = S_EMIT;
                end else begin
                    n_state = S_SHF_RD;
                end
            end
            S_SHF_RD: begin
                o_cmd.mem_rd  = 1'b1;
                o_cmd.rd_next = 1'b1;
                n_state       = S_SHF_WR;
            end
            S_SHF_WR: begin
                o_cmd.mem_wr   = 1'b1;
                o_cmd.wr_shift = 1'b1;
                o_cmd.idx_inc  = 1'b1;
                n_state        = S_SHF_CHK;
            end
            S_DSP_RD: begin
                o_cmd.mem_rd = 1'b1;
                n_state      = S_DSP_OUT;
            end
            S_DSP_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load   = 1'b1;
                    o_cmd.out_status = ST_LISTED;
                    o_cmd.out_rdata  = 1'b1;
                    o_cmd.out_last   = i_sts.list_last;
                    if (i_sts.list_last) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.idx_inc = 1'b1;
                        n_state       = S_DSP_RD;
                    end
                end
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load   = 1'b1;
                    o_cmd.out_status = r_pend;
                    o_cmd.out_last   = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pend  <= ST_APPENDED;
        end else begin
            r_state <= n_state;
            r_pend  <= n_pend;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/ordered_list_append_delete.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ordered_list_append_delete
// ordered list of signed 32-bit values with append, delete-first-match and
// display commands, one command per input transaction
// ----------------------------------------------------------------------------
// Holds up to CAPACITY values in a storage array with separate read and write
// addresses, head at index 0. One command is worked at a time; the input is taken
// again as soon as the sequencer is back in idle, even while the last result still
// waits in the output register. Append writes the value at the tail; an unknown
// command gives no result. Delete reads and compares the entries from the head up
// to the first match, then moves each entry behind the match one place down, a read
// and then a write per entry. Display reads and lists the entries from the head, at
// most 16 entries. A result waits until the output register is free. The storage
// array gives at most one read per cycle, registered before it can be compared,
// listed or moved. Storage needs no clearing after reset: only entries below the
// count are ever read.
// ----------------------------------------------------------------------------
module ordered_list_append_delete
    import olad_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    // command transaction
    input  wire                i_in_valid,
    output logic               o_in_ready,
    input  wire  [1:0]         i_command,
    input  wire  signed [31:0] i_value,
    // result transaction
    output logic               o_out_valid,
    input  wire                i_out_ready,
    output logic [2:0]         o_status,
    output logic signed [31:0] o_entry_value,
    output logic               o_last
);

    // command and status bundles between sequencer and datapath
    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    // sequencer: decodes the latched command and steps through search,
    // compaction and listing one storage access at a time
    olad_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (dp_sts),
        .o_cmd      (dp_cmd)
    );

    // datapath: storage, count, walk index and the result register that
    // separates the output from the sequencer
    olad_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_command     (i_command),
        .i_value       (i_value),
        .i_out_ready   (i_out_ready),
        .i_cmd         (dp_cmd),
        .o_sts         (dp_sts),
        .o_out_valid   (o_out_valid),
        .o_status      (o_status),
        .o_entry_value (o_entry_value),
        .o_last        (o_last)
    );

endmodule
`default_nettype wire

// ----- verif/list_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// list_checker
// watches the command and result channels of the ordered list, keeps its own
// copy of the list, works out the results each command should give and
// compares every result with the oldest one still owed
// ----------------------------------------------------------------------------
module list_checker
    import olad_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_in_valid,
    input  wire                i_in_ready,
    input  wire  [1:0]         i_command,
    input  wire  signed [31:0] i_value,
    input  wire                i_out_valid,
    input  wire                i_out_ready,
    input  wire  [2:0]         i_status,
    input  wire  signed [31:0] i_entry_value,
    input  wire                i_last,
    output int                 o_fail_count,
    output int                 o_pending
);

    typedef struct packed {
        t_status     status;
        logic [31:0] entry_value;
        logic        last;
    } t_list_result;

    logic signed [31:0] held_values [CAPACITY];
    int                 held_count;
    t_list_result       owed_results [$];
    t_list_result       oldest;
    int                 fail_count = 0;

    assign o_fail_count = fail_count;

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t ns: %s", $time, msg);
        fail_count++;
    endtask

    task automatic owe_result(input t_status status, input logic [31:0] v, input logic last);
        t_list_result r;
        r.status      = status;
        r.entry_value = v;
        r.last        = last;
        owed_results.push_back(r);
    endtask

    // update the list copy and queue what the command must produce
    task automatic apply_command(input logic [1:0] cmd, input logic signed [31:0] v);
        int pos;
        int n;
        case (cmd)
            CMD_APPEND: begin
                if (held_count >= CAPACITY) begin
                    owe_result(ST_FULL, v, 1'b1);
                end else begin
                    held_values[held_count] = v;
                    held_count++;
                    owe_result(ST_APPENDED, v, 1'b1);
                end
            end
            CMD_DELETE: begin
                if (held_count == 0) begin
                    owe_result(ST_EMPTY, v, 1'b1);
                end else begin
                    pos = 0;
                    while (pos < held_count && held_values[pos] !== v)
                        pos++;
                    if (pos == held_count) begin
                        owe_result(ST_NOT_FOUND, v, 1'b1);
                    end else begin
                        // close the gap, order kept
                        for (; pos + 1 < held_count; pos++)
                            held_values[pos] = held_values[pos + 1];
                        held_count--;
                        owe_result(ST_DELETED, v, 1'b1);
                    end
                end
            end
            CMD_DISPLAY: begin
                if (held_count == 0) begin
                    owe_result(ST_EMPTY, v, 1'b1);
                end else begin
                    n = (held_count > RESULT_LIMIT) ? RESULT_LIMIT : held_count;
                    for (pos = 0; pos < n; pos++)
                        owe_result(ST_LISTED, held_values[pos], pos == n - 1);
                end
            end
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            held_count = 0;
            owed_results.delete();
            o_pending <= 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (owed_results.size() == 0) begin
                    report_mismatch($sformatf("result with nothing owed: status %0d value %h",
                                              i_status, i_entry_value));
                end else begin
                    oldest = owed_results.pop_front();
                    if (i_status !== oldest.status)
                        report_mismatch($sformatf("status %0d, wanted %0d",
                                                  i_status, oldest.status));
                    if (i_entry_value !== oldest.entry_value)
                        report_mismatch($sformatf("entry value %h, wanted %h",
                                                  i_entry_value, oldest.entry_value));
                    if (i_last !== oldest.last)
                        report_mismatch($sformatf("last %b, wanted %b",
                                                  i_last, oldest.last));
                end
            end
            if (i_in_valid && i_in_ready)
                apply_command(i_command, i_value);
            o_pending <= owed_results.size();
        end
    end

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// command stimulus and verdict for the ordered list block
// ----------------------------------------------------------------------------
// A short directed run covers empty, duplicate, head, tail and not-found cases
// and the unused command code; then random segments fill the list, drain it
// or mix commands, with values mostly drawn from a small pool so that deletes
// find their targets. Both channels idle at random; the checker beside the
// block predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;
    import olad_pkg::*;

    localparam int          CAPACITY     = 16;
    localparam int          RANDOM_ITEMS = 240;
    localparam int          POOL_SIZE    = 10;
    localparam logic [1:0]  CMD_UNUSED   = 2'd3;
    localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] VAL_MAX = 32'sh7FFF_FFFF;

    typedef enum {SEG_FILL, SEG_DRAIN, SEG_MIXED, SEG_BURST} t_segment;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic               in_ready;
    logic [1:0]         command   = CMD_APPEND;
    logic signed [31:0] value_in  = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [2:0]         status;
    logic signed [31:0] entry_value;
    logic               last;
    int                 fail_count;
    int                 pending;

    // idling switched off for burst segments
    bit                 idle_off  = 1'b0;
    int                 stall_left = 0;
    int                 items_sent = 0;
    logic signed [31:0] pool [POOL_SIZE];

    always #2 clk = ~clk;

    ordered_list_append_delete #(
        .CAPACITY      (CAPACITY)
    ) dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_ready    (in_ready),
        .i_command     (command),
        .i_value       (value_in),
        .o_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .o_status      (status),
        .o_entry_value (entry_value),
        .o_last        (last)
    );

    list_checker #(
        .CAPACITY      (CAPACITY)
    ) u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_ready    (in_ready),
        .i_command     (command),
        .i_value       (value_in),
        .i_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .i_status      (status),
        .i_entry_value (entry_value),
        .i_last        (last),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    // mostly no gap or a short one, now and then a long one
    function automatic int gap_cycles();
        int r;
        r = $urandom_range(0, 99);
        if (idle_off || r < 50)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // result side back-pressure
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else if (stall_left > 0) begin
            out_ready <= 1'b0;
            stall_left--;
        end else begin
            out_ready <= 1'b1;
            if ($urandom_range(0, 3) == 0)
                stall_left = gap_cycles();
        end
    end

    // one command transaction; valid stays high when no gap follows
    task automatic send_command(input logic [1:0] cmd, input logic signed [31:0] v);
        int gap;
        gap = gap_cycles();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        command  <= cmd;
        value_in <= v;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (cmd != CMD_UNUSED)
            items_sent++;
    endtask

    // hold off until every owed result has come out
    task automatic wait_for_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    function automatic logic signed [31:0] pool_value();
        return pool[$urandom_range(0, POOL_SIZE - 1)];
    endfunction

    task automatic send_noise();
        send_command(2'($urandom_range(0, 3)), $urandom);
    endtask

    initial begin
        t_segment seg;
        int       seg_len;
        int       r;
        int       random_start;

        pool[0] = VAL_MIN;
        pool[1] = VAL_MAX;
        pool[2] = '0;
        pool[3] = -32'sd1;
        for (int k = 4; k < POOL_SIZE; k++)
            pool[k] = $urandom;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty list behaviour and the unused code
        send_command(CMD_DISPLAY, $urandom);
        send_command(CMD_DELETE, $urandom);
        send_command(CMD_UNUSED, $urandom);
        // extremes and a duplicate
        send_command(CMD_APPEND, VAL_MIN);
        send_command(CMD_APPEND, VAL_MAX);
        send_command(CMD_APPEND, '0);
        send_command(CMD_APPEND, VAL_MAX);
        send_command(CMD_APPEND, -32'sd1);
        send_command(CMD_DISPLAY, $urandom);
        // first match only, then a miss, then head and tail
        send_command(CMD_DELETE, VAL_MAX);
        send_command(CMD_DELETE, 32'sh1234_5679);
        send_command(CMD_DELETE, VAL_MIN);
        send_command(CMD_DELETE, -32'sd1);
        send_command(CMD_DISPLAY, $urandom);
        send_command(CMD_UNUSED, $urandom);

        // random segments, the first one filling the list to the brim
        random_start = items_sent;
        seg = SEG_FILL;
        seg_len = 26;
        while (items_sent < random_start + RANDOM_ITEMS) begin
            idle_off = (seg == SEG_BURST);
            for (int k = 0; k < seg_len; k++) begin
                r = $urandom_range(0, 99);
                case (seg)
                    SEG_FILL: begin
                        if (r < 75)      send_command(CMD_APPEND, pool_value());
                        else if (r < 85) send_command(CMD_DISPLAY, $urandom);
                        else if (r < 95) send_command(CMD_DELETE, pool_value());
                        else             send_noise();
                    end
                    SEG_DRAIN: begin
                        if (r < 65)      send_command(CMD_DELETE, pool_value());
                        else if (r < 80) send_command(CMD_APPEND, pool_value());
                        else if (r < 95) send_command(CMD_DISPLAY, $urandom);
                        else             send_noise();
                    end
                    default: begin
                        if (r < 30)      send_command(CMD_APPEND, pool_value());
                        else if (r < 60) send_command(CMD_DELETE, pool_value());
                        else if (r < 90) send_command(CMD_DISPLAY, $urandom);
                        else             send_noise();
                    end
                endcase
            end
            // after a fill segment the list gets one more append and is listed
            if (seg == SEG_FILL) begin
                send_command(CMD_APPEND, $urandom);
                send_command(CMD_DISPLAY, $urandom);
            end
            if (random_start + 30 > items_sent || $urandom_range(0, 2) == 0)
                wait_for_results();
            seg = t_segment'($urandom_range(0, 3));
            seg_len = $urandom_range(10, 30);
        end
        idle_off = 1'b0;

        wait_for_results();
        repeat (100) @(posedge clk);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // watchdog
    initial begin
        #3_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
